### src/tlks_pkg.sv
// ----------------------------------------------------------------------------
// tlks_pkg
// Shared widths, constants and types of the two-link knee solver.
// ----------------------------------------------------------------------------
package tlks_pkg;

    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = 24;
    localparam int LEN_W     = 23;
    localparam int LSQ_W     = 2 * LEN_W;
    localparam int D_W       = COORD_W + 1;
    localparam int SQ_W      = 2 * D_W;
    localparam int SQ_R      = SQ_W / 2;
    localparam int SQ_REM_W  = SQ_R + 2;
    localparam int NUM_W     = SQ_W + 2;
    localparam int A_W       = 33;
    localparam int PA_W      = A_W + D_W;
    localparam int SUM_W     = PA_W + 1;
    localparam int DIV_W     = SUM_W;
    localparam int DVS_W     = D_W + 1;
    localparam int SDATA_W   = 6 * COORD_W;
    localparam int MDATA_W   = 56;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] UPPER_RESET = LEN_W'(50 << FRAC_BITS);
    localparam logic [LEN_W-1:0] LOWER_RESET = LEN_W'(60 << FRAC_BITS);
    localparam logic [DIV_W-1:0] A_LIM = {{(DIV_W-A_W+1){1'b0}}, 1'b1, {(A_W-2){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        ST_REACH = 2'd0,
        ST_FAR   = 2'd1,
        ST_CLOSE = 2'd2,
        ST_SAME  = 2'd3
    } status_t;

endpackage

### src/two_link_knee_solver.sv
// ----------------------------------------------------------------------------
// two_link_knee_solver
// Two-link inverse kinematics: the knee point nearer the current knee.
// ----------------------------------------------------------------------------
// The s_ channel takes one word per solve: root, end and current middle
// point, each a signed Q16.8 coordinate. The m_ channel returns one word per
// solve: the solved middle point and a reach status. The user must write
// the two link lengths through the cfg_ port only while the block is idle;
// the block itself does not enforce this. The block is a pipeline of 185
// register stages, followed by the output register. One word is accepted
// in every cycle unless the pipeline is stalled (see below); the depth is
// set by two square root pipelines of 25 stages and two divider pipelines
// of 59 stages, one quotient bit each. A synchronous low aresetn empties
// the pipeline and the output buffer and loads the default link lengths.
// When the receiver stalls, the output register holds its word and a second
// buffer takes the next one; the pipeline and s_tready stop only while that
// buffer is full, so no word is lost or repeated.
// ----------------------------------------------------------------------------
module two_link_knee_solver import tlks_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // root_x, root_y, end_x, end_y, prior_mid_x, prior_mid_y
    input  logic [SDATA_W-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // mid_x, mid_y, reach_status, zero fill
    output logic [MDATA_W-1:0]   m_tdata
);

    typedef struct packed {
        coord_t rx;
        coord_t ry;
        coord_t px;
        coord_t py;
    } pts_t;

    typedef struct packed {
        pts_t                     pts;
        logic signed [D_W-1:0]    dx;
        logic signed [D_W-1:0]    dy;
        logic                     zero;
        status_t                  status;
        logic [NUM_W-2:0]         num_mag;
        logic                     num_neg;
        logic [LSQ_W-1:0]         l1sq;
    } side_a_t;

    typedef struct packed {
        pts_t                     pts;
        logic signed [D_W-1:0]    dx;
        logic signed [D_W-1:0]    dy;
        logic                     zero;
        status_t                  status;
        logic [LSQ_W-1:0]         l1sq;
        logic [SQ_R-1:0]          d;
    } side_b_t;

    typedef struct packed {
        pts_t                     pts;
        logic signed [D_W-1:0]    dx;
        logic signed [D_W-1:0]    dy;
        logic                     zero;
        status_t                  status;
        logic [SQ_R-1:0]          d;
        logic signed [A_W-1:0]    a;
    } side_c_t;

    typedef struct packed {
        pts_t                     pts;
        logic                     zero;
        status_t                  status;
    } side_d_t;

    localparam logic signed [DIV_W+1:0] COORD_MAX_S = (DIV_W+2)'((1 << (COORD_W-1)) - 1);
    localparam logic signed [DIV_W+1:0] COORD_MIN_S = -((DIV_W+2)'(1 << (COORD_W-1)));

    function automatic coord_t sat_add(logic signed [DIV_W:0] q, coord_t base);
        logic signed [DIV_W+1:0] s;
        s = q + base;
        if (s > COORD_MAX_S) begin
            return coord_t'(COORD_MAX_S);
        end else if (s < COORD_MIN_S) begin
            return coord_t'(COORD_MIN_S);
        end
        return s[COORD_W-1:0];
    endfunction

    logic [LEN_W-1:0] upper_length_reg;
    logic [LEN_W-1:0] lower_length_reg;

    logic en;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic v8_reg, v9_reg, v10_reg, v11_reg, v12_reg, v13_reg, v14_reg, v15_reg, v16_reg;

    pts_t                  pts0_reg, pts1_reg, pts2_reg, pts3_reg, pts4_reg;
    logic signed [D_W-1:0] dx0_reg, dy0_reg, dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [D_W-1:0] dx3_reg, dy3_reg, dx4_reg, dy4_reg;
    logic [SQ_W-1:0]       dxx1_reg, dyy1_reg, d2_2_reg, d2_3_reg, d2_4_reg;
    logic [LSQ_W-1:0]      l1sq1_reg, l2sq1_reg, l1sq2_reg, l2sq2_reg, l1sq3_reg, l1sq4_reg;
    logic [LSQ_W+1:0]      sumsq1_reg, sumsq2_reg;
    logic [LSQ_W-1:0]      difsq1_reg, difsq2_reg;
    logic signed [NUM_W-1:0] num3_reg;
    logic                  zero3_reg, zero4_reg;
    status_t               status3_reg, status4_reg;
    logic [NUM_W-2:0]      num_mag4_reg;
    logic                  num_neg4_reg;

    side_a_t sa_reg [SQ_R];
    side_b_t sb_reg [DIV_W];
    side_c_t sc_reg [SQ_R];
    side_d_t sd_reg [DIV_W];
    side_a_t sa_in;
    side_b_t sb_in;
    side_c_t sc_in;
    side_d_t sd_in;

    side_b_t               b5_reg, b6_reg, b7_reg;
    logic signed [A_W-1:0] a5_reg, a6_reg, a7_reg;
    logic [2*A_W-3:0]      asq6_reg;
    logic [SQ_W-1:0]       hrad7_reg;

    side_c_t               c8_reg, c9_reg, c10_reg;
    logic signed [PA_W-1:0] adx8_reg, ady8_reg, hdx8_reg, hdy8_reg;
    logic signed [SUM_W-1:0] n9_reg [4];
    logic [DIV_W-1:0]      mag10_reg [4];
    logic [3:0]            neg10_reg;

    side_d_t               d11_reg, d12_reg, d13_reg, d14_reg, d15_reg;
    logic signed [DIV_W:0] qs11_reg [4];
    coord_t                k12_reg [4];
    coord_t                k13_reg [4];
    coord_t                k14_reg [4];
    coord_t                k15_reg [4];
    logic signed [D_W-1:0] e13_reg [4];
    logic [SQ_W-1:0]       e14_reg [4];
    logic [SQ_W:0]         dist1_15_reg, dist2_15_reg;
    logic [MDATA_W-1:0]    pipe16_reg;

    logic [MDATA_W-1:0]    out_data_reg;
    logic [MDATA_W-1:0]    skid_data_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;

    logic                  sq1_v, sq2_v, div1_v, div1_neg;
    logic [SQ_R-1:0]       sq1_root, sq2_root;
    logic [DIV_W-1:0]      div1_q;
    logic [3:0]            div2_v, div2_neg;
    logic [DIV_W-1:0]      div2_q [4];

    coord_t                in_rx, in_ry, in_ex, in_ey, in_px, in_py;
    logic [LEN_W:0]        len_sum;
    logic [LEN_W-1:0]      len_dif;
    logic signed [SQ_W-1:0] dxx_c, dyy_c;
    logic signed [NUM_W-1:0] num_c;
    logic [A_W-1:0]        amag_c;
    logic signed [2*A_W-1:0] asq_c;
    logic signed [D_W:0]   h_c;
    logic signed [SQ_W-1:0] esq_c [4];
    logic                  pick1_c;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign in_rx = s_tdata[COORD_W-1:0];
    assign in_ry = s_tdata[2*COORD_W-1:COORD_W];
    assign in_ex = s_tdata[3*COORD_W-1:2*COORD_W];
    assign in_ey = s_tdata[4*COORD_W-1:3*COORD_W];
    assign in_px = s_tdata[5*COORD_W-1:4*COORD_W];
    assign in_py = s_tdata[6*COORD_W-1:5*COORD_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_length_reg <= UPPER_RESET;
            lower_length_reg <= LOWER_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_UPPER) begin
                upper_length_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_LOWER) begin
                lower_length_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        len_sum = {1'b0, upper_length_reg} + {1'b0, lower_length_reg};
        len_dif = (upper_length_reg > lower_length_reg) ?
                  upper_length_reg - lower_length_reg : lower_length_reg - upper_length_reg;
        dxx_c   = dx0_reg * dx0_reg;
        dyy_c   = dy0_reg * dy0_reg;
        num_c   = {{(NUM_W-LSQ_W){1'b0}}, l1sq2_reg} - {{(NUM_W-LSQ_W){1'b0}}, l2sq2_reg}
                + {2'b00, d2_2_reg};
        amag_c  = (div1_q > A_LIM) ? A_LIM[A_W-1:0] : div1_q[A_W-1:0];
        asq_c   = a5_reg * a5_reg;
        h_c     = $signed({1'b0, sq2_root});
        for (int i = 0; i < 4; i++) begin
            esq_c[i] = e13_reg[i] * e13_reg[i];
        end
        pick1_c = dist1_15_reg < dist2_15_reg;
    end

    always_comb begin
        sa_in.pts     = pts4_reg;
        sa_in.dx      = dx4_reg;
        sa_in.dy      = dy4_reg;
        sa_in.zero    = zero4_reg;
        sa_in.status  = status4_reg;
        sa_in.num_mag = num_mag4_reg;
        sa_in.num_neg = num_neg4_reg;
        sa_in.l1sq    = l1sq4_reg;
        sb_in.pts     = sa_reg[SQ_R-1].pts;
        sb_in.dx      = sa_reg[SQ_R-1].dx;
        sb_in.dy      = sa_reg[SQ_R-1].dy;
        sb_in.zero    = sa_reg[SQ_R-1].zero;
        sb_in.status  = sa_reg[SQ_R-1].status;
        sb_in.l1sq    = sa_reg[SQ_R-1].l1sq;
        sb_in.d       = sq1_root;
        sc_in.pts     = b7_reg.pts;
        sc_in.dx      = b7_reg.dx;
        sc_in.dy      = b7_reg.dy;
        sc_in.zero    = b7_reg.zero;
        sc_in.status  = b7_reg.status;
        sc_in.d       = b7_reg.d;
        sc_in.a       = a7_reg;
        sd_in.pts     = c10_reg.pts;
        sd_in.zero    = c10_reg.zero;
        sd_in.status  = c10_reg.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            {v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg} <= '0;
            {v8_reg, v9_reg, v10_reg, v11_reg, v12_reg, v13_reg} <= '0;
            {v14_reg, v15_reg, v16_reg} <= '0;
        end else if (en) begin
            v0_reg  <= s_tvalid;
            v1_reg  <= v0_reg;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= div1_v;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= sq2_v;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= &div2_v;
            v12_reg <= v11_reg;
            v13_reg <= v12_reg;
            v14_reg <= v13_reg;
            v15_reg <= v14_reg;
            v16_reg <= v15_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pts0_reg <= '{rx: in_rx, ry: in_ry, px: in_px, py: in_py};
            dx0_reg  <= {in_ex[COORD_W-1], in_ex} - {in_rx[COORD_W-1], in_rx};
            dy0_reg  <= {in_ey[COORD_W-1], in_ey} - {in_ry[COORD_W-1], in_ry};

            pts1_reg   <= pts0_reg;
            dx1_reg    <= dx0_reg;
            dy1_reg    <= dy0_reg;
            dxx1_reg   <= dxx_c;
            dyy1_reg   <= dyy_c;
            l1sq1_reg  <= upper_length_reg * upper_length_reg;
            l2sq1_reg  <= lower_length_reg * lower_length_reg;
            sumsq1_reg <= len_sum * len_sum;
            difsq1_reg <= len_dif * len_dif;

            pts2_reg   <= pts1_reg;
            dx2_reg    <= dx1_reg;
            dy2_reg    <= dy1_reg;
            d2_2_reg   <= dxx1_reg + dyy1_reg;
            l1sq2_reg  <= l1sq1_reg;
            l2sq2_reg  <= l2sq1_reg;
            sumsq2_reg <= sumsq1_reg;
            difsq2_reg <= difsq1_reg;

            pts3_reg  <= pts2_reg;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            d2_3_reg  <= d2_2_reg;
            l1sq3_reg <= l1sq2_reg;
            num3_reg  <= num_c;
            zero3_reg <= (d2_2_reg == '0);
            if (d2_2_reg > sumsq2_reg) begin
                status3_reg <= ST_FAR;
            end else if (d2_2_reg < difsq2_reg) begin
                status3_reg <= ST_CLOSE;
            end else begin
                status3_reg <= ST_REACH;
            end

            pts4_reg     <= pts3_reg;
            dx4_reg      <= dx3_reg;
            dy4_reg      <= dy3_reg;
            d2_4_reg     <= d2_3_reg;
            l1sq4_reg    <= l1sq3_reg;
            zero4_reg    <= zero3_reg;
            status4_reg  <= status3_reg;
            num_neg4_reg <= num3_reg[NUM_W-1];
            num_mag4_reg <= num3_reg[NUM_W-1] ? (NUM_W-1)'(-num3_reg) : (NUM_W-1)'(num3_reg);

            sa_reg[0] <= sa_in;
            for (int i = 1; i < SQ_R; i++) begin
                sa_reg[i] <= sa_reg[i-1];
            end
            sb_reg[0] <= sb_in;
            for (int i = 1; i < DIV_W; i++) begin
                sb_reg[i] <= sb_reg[i-1];
            end

            b5_reg   <= sb_reg[DIV_W-1];
            a5_reg   <= div1_neg ? -$signed(amag_c) : $signed(amag_c);
            b6_reg   <= b5_reg;
            a6_reg   <= a5_reg;
            asq6_reg <= asq_c[2*A_W-3:0];
            b7_reg   <= b6_reg;
            a7_reg   <= a6_reg;
            if (asq6_reg >= {{(2*A_W-2-LSQ_W){1'b0}}, b6_reg.l1sq}) begin
                hrad7_reg <= '0;
            end else begin
                hrad7_reg <= {{(SQ_W-LSQ_W){1'b0}}, b6_reg.l1sq - asq6_reg[LSQ_W-1:0]};
            end

            sc_reg[0] <= sc_in;
            for (int i = 1; i < SQ_R; i++) begin
                sc_reg[i] <= sc_reg[i-1];
            end

            c8_reg   <= sc_reg[SQ_R-1];
            adx8_reg <= sc_reg[SQ_R-1].a * sc_reg[SQ_R-1].dx;
            ady8_reg <= sc_reg[SQ_R-1].a * sc_reg[SQ_R-1].dy;
            hdx8_reg <= h_c * sc_reg[SQ_R-1].dx;
            hdy8_reg <= h_c * sc_reg[SQ_R-1].dy;

            c9_reg    <= c8_reg;
            n9_reg[0] <= SUM_W'(adx8_reg) - SUM_W'(hdy8_reg);
            n9_reg[1] <= SUM_W'(ady8_reg) + SUM_W'(hdx8_reg);
            n9_reg[2] <= SUM_W'(adx8_reg) + SUM_W'(hdy8_reg);
            n9_reg[3] <= SUM_W'(ady8_reg) - SUM_W'(hdx8_reg);

            c10_reg <= c9_reg;
            for (int i = 0; i < 4; i++) begin
                neg10_reg[i] <= n9_reg[i][SUM_W-1];
                mag10_reg[i] <= n9_reg[i][SUM_W-1] ? DIV_W'(-n9_reg[i]) : DIV_W'(n9_reg[i]);
            end

            sd_reg[0] <= sd_in;
            for (int i = 1; i < DIV_W; i++) begin
                sd_reg[i] <= sd_reg[i-1];
            end

            d11_reg <= sd_reg[DIV_W-1];
            for (int i = 0; i < 4; i++) begin
                qs11_reg[i] <= div2_neg[i] ? -$signed({1'b0, div2_q[i]}) : $signed({1'b0, div2_q[i]});
            end

            d12_reg    <= d11_reg;
            k12_reg[0] <= sat_add(qs11_reg[0], d11_reg.pts.rx);
            k12_reg[1] <= sat_add(qs11_reg[1], d11_reg.pts.ry);
            k12_reg[2] <= sat_add(qs11_reg[2], d11_reg.pts.rx);
            k12_reg[3] <= sat_add(qs11_reg[3], d11_reg.pts.ry);

            d13_reg <= d12_reg;
            for (int i = 0; i < 4; i++) begin
                k13_reg[i] <= k12_reg[i];
                e13_reg[i] <= (i % 2 == 0) ?
                              {k12_reg[i][COORD_W-1], k12_reg[i]} - {d12_reg.pts.px[COORD_W-1], d12_reg.pts.px} :
                              {k12_reg[i][COORD_W-1], k12_reg[i]} - {d12_reg.pts.py[COORD_W-1], d12_reg.pts.py};
            end

            d14_reg <= d13_reg;
            for (int i = 0; i < 4; i++) begin
                k14_reg[i] <= k13_reg[i];
                e14_reg[i] <= esq_c[i];
            end

            d15_reg      <= d14_reg;
            k15_reg      <= k14_reg;
            dist1_15_reg <= {1'b0, e14_reg[0]} + {1'b0, e14_reg[1]};
            dist2_15_reg <= {1'b0, e14_reg[2]} + {1'b0, e14_reg[3]};

            if (d15_reg.zero) begin
                pipe16_reg <= {{(MDATA_W-2*COORD_W-2){1'b0}}, ST_SAME, d15_reg.pts.py, d15_reg.pts.px};
            end else if (pick1_c) begin
                pipe16_reg <= {{(MDATA_W-2*COORD_W-2){1'b0}}, d15_reg.status, k15_reg[1], k15_reg[0]};
            end else begin
                pipe16_reg <= {{(MDATA_W-2*COORD_W-2){1'b0}}, d15_reg.status, k15_reg[3], k15_reg[2]};
            end
        end
    end

    tlks_sqrt u_sqrt_d (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v4_reg),
        .in_rad   (d2_4_reg),
        .out_valid(sq1_v),
        .out_root (sq1_root)
    );

    tlks_div u_div_a (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (sq1_v),
        .in_dividend({{(DIV_W-NUM_W+1){1'b0}}, sa_reg[SQ_R-1].num_mag}),
        .in_divisor ({sq1_root, 1'b0}),
        .in_neg     (sa_reg[SQ_R-1].num_neg),
        .out_valid  (div1_v),
        .out_quot   (div1_q),
        .out_neg    (div1_neg)
    );

    tlks_sqrt u_sqrt_h (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v7_reg),
        .in_rad   (hrad7_reg),
        .out_valid(sq2_v),
        .out_root (sq2_root)
    );

    for (genvar g = 0; g < 4; g++) begin : g_proj
        tlks_div u_div_p (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .in_valid   (v10_reg),
            .in_dividend(mag10_reg[g]),
            .in_divisor ({1'b0, c10_reg.d}),
            .in_neg     (neg10_reg[g]),
            .out_valid  (div2_v[g]),
            .out_quot   (div2_q[g]),
            .out_neg    (div2_neg[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg || (v16_reg && en);
            skid_valid_reg <= 1'b0;
        end else if (v16_reg && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : pipe16_reg;
        end else if (v16_reg && en) begin
            skid_data_reg <= pipe16_reg;
        end
    end

    a_skid_has_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer full while output register empty");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid word lost during stall");

    a_pipe_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(v16_reg) && $stable(pipe16_reg)))
        else $error("pipeline moved while frozen");

endmodule

### src/tlks_sqrt.sv
// ----------------------------------------------------------------------------
// tlks_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module tlks_sqrt import tlks_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [SQ_W-1:0] in_rad,
    output logic            out_valid,
    output logic [SQ_R-1:0] out_root
);

    logic [SQ_W-1:0]     rad_reg [SQ_R];
    logic [SQ_W-1:0]     rad_src [SQ_R];
    logic [SQ_REM_W-1:0] rem_reg [SQ_R];
    logic [SQ_REM_W-1:0] rem_src [SQ_R];
    logic [SQ_R-1:0]     root_reg [SQ_R];
    logic [SQ_R-1:0]     root_src [SQ_R];
    logic [SQ_R-1:0]     v_reg;
    logic [SQ_R-1:0]     v_src;
    logic [SQ_REM_W+1:0] t_c [SQ_R];
    logic [SQ_REM_W+1:0] trial_c [SQ_R];
    logic [SQ_REM_W+1:0] diff_c [SQ_R];
    logic [SQ_R-1:0]     ge_c;

    always_comb begin
        rad_src[0]  = in_rad;
        rem_src[0]  = '0;
        root_src[0] = '0;
        v_src[0]    = in_valid;
        for (int k = 1; k < SQ_R; k++) begin
            rad_src[k]  = rad_reg[k-1];
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            v_src[k]    = v_reg[k-1];
        end
        for (int k = 0; k < SQ_R; k++) begin
            t_c[k]     = {rem_src[k], rad_src[k][SQ_W-1 -: 2]};
            trial_c[k] = {2'b00, root_src[k], 2'b01};
            ge_c[k]    = t_c[k] >= trial_c[k];
            diff_c[k]  = t_c[k] - trial_c[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_src;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_R; k++) begin
                rad_reg[k]  <= {rad_src[k][SQ_W-3:0], 2'b00};
                rem_reg[k]  <= ge_c[k] ? diff_c[k][SQ_REM_W-1:0] : t_c[k][SQ_REM_W-1:0];
                root_reg[k] <= {root_src[k][SQ_R-2:0], ge_c[k]};
            end
        end
    end

    assign out_valid = v_reg[SQ_R-1];
    assign out_root  = root_reg[SQ_R-1];

endmodule

### src/tlks_div.sv
// ----------------------------------------------------------------------------
// tlks_div
// Pipelined restoring divider of a magnitude, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tlks_div import tlks_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DIV_W-1:0] in_dividend,
    input  logic [DVS_W-1:0] in_divisor,
    input  logic             in_neg,
    output logic             out_valid,
    output logic [DIV_W-1:0] out_quot,
    output logic             out_neg
);

    logic [DIV_W-1:0] work_reg [DIV_W];
    logic [DIV_W-1:0] work_src [DIV_W];
    logic [DVS_W-1:0] rem_reg [DIV_W];
    logic [DVS_W-1:0] rem_src [DIV_W];
    logic [DVS_W-1:0] dvs_reg [DIV_W];
    logic [DVS_W-1:0] dvs_src [DIV_W];
    logic [DIV_W-1:0] neg_reg;
    logic [DIV_W-1:0] neg_src;
    logic [DIV_W-1:0] v_reg;
    logic [DIV_W-1:0] v_src;
    logic [DVS_W:0]   t_c [DIV_W];
    logic [DVS_W:0]   diff_c [DIV_W];
    logic [DIV_W-1:0] ge_c;

    always_comb begin
        work_src[0] = in_dividend;
        rem_src[0]  = '0;
        dvs_src[0]  = in_divisor;
        neg_src[0]  = in_neg;
        v_src[0]    = in_valid;
        for (int k = 1; k < DIV_W; k++) begin
            work_src[k] = work_reg[k-1];
            rem_src[k]  = rem_reg[k-1];
            dvs_src[k]  = dvs_reg[k-1];
            neg_src[k]  = neg_reg[k-1];
            v_src[k]    = v_reg[k-1];
        end
        for (int k = 0; k < DIV_W; k++) begin
            t_c[k]    = {rem_src[k], work_src[k][DIV_W-1]};
            ge_c[k]   = t_c[k] >= {1'b0, dvs_src[k]};
            diff_c[k] = t_c[k] - {1'b0, dvs_src[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_src;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg <= neg_src;
            for (int k = 0; k < DIV_W; k++) begin
                work_reg[k] <= {work_src[k][DIV_W-2:0], ge_c[k]};
                rem_reg[k]  <= ge_c[k] ? diff_c[k][DVS_W-1:0] : t_c[k][DVS_W-1:0];
                dvs_reg[k]  <= dvs_src[k];
            end
        end
    end

    assign out_valid = v_reg[DIV_W-1];
    assign out_quot  = work_reg[DIV_W-1];
    assign out_neg   = neg_reg[DIV_W-1];

endmodule

### sim/tb_two_link_knee_solver.sv
// ----------------------------------------------------------------------------
// tb_two_link_knee_solver
// Self-checking testbench of the two-link knee solver.
// ----------------------------------------------------------------------------
// Each accepted input word is solved by a model in the testbench, and the
// result words are compared field by field in arrival order. Directed words
// cover the reach cases and the coordinate extremes. Several link-length
// settings follow, the extremes among them, each with random point sets.
// Both sides idle at random, and the receiver also holds off for a long
// stretch so that the pipeline fills up.
// ----------------------------------------------------------------------------
module tb_two_link_knee_solver;
    import tlks_pkg::*;

    localparam int PIPE_WAIT  = 200;
    localparam int STALL_LEN  = 400;
    localparam int STALL_LIMIT = 3000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [SDATA_W-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [MDATA_W-1:0]   m_tdata;

    logic [LEN_W-1:0] upper_len;
    logic [LEN_W-1:0] lower_len;
    logic [MDATA_W-1:0] knee_expected[$];
    bit   idle_on;
    int   hold_left;
    int   errors;
    int   solves_in;
    int   solves_out;
    int   status_seen[4];
    int   quiet_cycles;

    two_link_knee_solver uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic logic [MDATA_W-1:0] solve_knee(logic [SDATA_W-1:0] w);
        coord_t c[6];
        longint rx, ry, px, py, dx, dy, d2, l1, l2, sum, dif, d, a, h;
        longint k1x, k1y, k2x, k2y, mx, my, e1x, e1y, e2x, e2y;
        status_t st;
        for (int i = 0; i < 6; i++) c[i] = w[i*COORD_W +: COORD_W];
        rx = c[0]; ry = c[1]; px = c[4]; py = c[5];
        dx = longint'(c[2]) - rx;
        dy = longint'(c[3]) - ry;
        d2 = dx * dx + dy * dy;
        if (d2 == 0)
            return {6'd0, ST_SAME, c[5], c[4]};
        l1 = upper_len;
        l2 = lower_len;
        sum = l1 + l2;
        dif = (l1 > l2) ? l1 - l2 : l2 - l1;
        if (d2 > sum * sum) st = ST_FAR;
        else if (d2 < dif * dif) st = ST_CLOSE;
        else st = ST_REACH;
        d = int_sqrt(d2);
        a = (l1 * l1 - l2 * l2 + d2) / (2 * d);
        if (a > 64'sd2147483648) a = 64'sd2147483648;
        if (a < -64'sd2147483648) a = -64'sd2147483648;
        h = (a * a >= l1 * l1) ? 0 : longint'(int_sqrt(l1 * l1 - a * a));
        k1x = clamp_coord(rx + (a * dx - h * dy) / d);
        k1y = clamp_coord(ry + (a * dy + h * dx) / d);
        k2x = clamp_coord(rx + (a * dx + h * dy) / d);
        k2y = clamp_coord(ry + (a * dy - h * dx) / d);
        e1x = k1x - px; e1y = k1y - py;
        e2x = k2x - px; e2y = k2y - py;
        if (e1x * e1x + e1y * e1y < e2x * e2x + e2y * e2y) begin
            mx = k1x; my = k1y;
        end else begin
            mx = k2x; my = k2y;
        end
        return {6'd0, st, my[COORD_W-1:0], mx[COORD_W-1:0]};
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on word %0d: %s is %0d, expected %0d", solves_out, what, got, want);
    endtask

    // Input side: every accepted word is solved right away.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            knee_expected.push_back(solve_knee(s_tdata));
            solves_in++;
        end
    end

    // Output side: compare each word with the oldest expectation.
    always @(posedge aclk) begin
        logic [MDATA_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (knee_expected.size() == 0) begin
                report_mismatch("unexpected word, queue depth", 0, 0);
            end else begin
                want = knee_expected.pop_front();
                if (m_tdata[23:0] !== want[23:0])
                    report_mismatch("mid_x", coord_t'(m_tdata[23:0]), coord_t'(want[23:0]));
                if (m_tdata[47:24] !== want[47:24])
                    report_mismatch("mid_y", coord_t'(m_tdata[47:24]), coord_t'(want[47:24]));
                if (m_tdata[49:48] !== want[49:48])
                    report_mismatch("reach_status", m_tdata[49:48], want[49:48]);
                status_seen[want[49:48]]++;
            end
            solves_out++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= !idle_on || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_points(longint rx, longint ry, longint ex, longint ey,
                               longint px, longint py);
        while (idle_on && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {py[23:0], px[23:0], ey[23:0], ex[23:0], ry[23:0], rx[23:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (knee_expected.size() != 0) @(posedge aclk);
        repeat (PIPE_WAIT) @(posedge aclk);
    endtask

    task automatic write_length(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_UPPER) upper_len = val;
        else if (idx == CFG_LOWER) lower_len = val;
    endtask

    function automatic longint rand_full();
        return longint'(coord_t'($urandom()));
    endfunction

    // Mostly point sets near the reachable ring, the rest over the full range.
    task automatic send_random_points();
        longint span, rx, ry;
        span = longint'(upper_len) + longint'(lower_len);
        span = span + span / 2 + 256;
        if (span > 64'sd4194304) span = 64'sd4194304;
        if ($urandom_range(9) < 2) begin
            send_points(rand_full(), rand_full(), rand_full(), rand_full(),
                        rand_full(), rand_full());
        end else begin
            rx = longint'($urandom_range(2097152)) - 1048576;
            ry = longint'($urandom_range(2097152)) - 1048576;
            send_points(rx, ry,
                        rx + longint'($urandom_range(2 * span)) - span,
                        ry + longint'($urandom_range(2 * span)) - span,
                        rx + longint'($urandom_range(2 * span)) - span,
                        ry + longint'($urandom_range(2 * span)) - span);
        end
    endtask

    task automatic test_directed();
        send_points(0, 0, 0, 0, 8388607, -8388608);
        send_points(-8388608, 8388607, -8388608, 8388607, 12, -34);
        send_points(0, 0, 100 << 8, 0, 0, 50 << 8);
        send_points(0, 0, 100 << 8, 0, 0, -(50 << 8));
        send_points(0, 0, 110 << 8, 0, 7, 7);
        send_points(0, 0, 8388607, 0, 0, 0);
        send_points(0, 0, 5 << 8, 0, 0, 0);
        send_points(0, 0, 1, 0, 0, 0);
        send_points(-8388608, -8388608, 8388607, 8388607, 8388607, -8388608);
        send_points(8388607, 8388607, -8388608, -8388608, -8388608, 8388607);
        send_points(8388607, 8388607, 8388607, 8388000, 8388607, 8388607);
        send_points(-8388608, 0, -8388000, 0, -8388608, -8388608);
        send_points(300, -700, 300, 20000, 300, -700);
        send_points(0, 0, 0, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_length_settings();
        logic [LEN_W-1:0] up_set[6];
        logic [LEN_W-1:0] lo_set[6];
        up_set = '{0, 23'h7FFFFF, 23'h7FFFFF, 0, 23'd2560, 23'd40000};
        lo_set = '{0, 23'h7FFFFF, 0, 23'h7FFFFF, 23'd2560, 23'd9000};
        for (int s = 0; s < 6; s++) begin
            write_length(CFG_UPPER, up_set[s]);
            write_length(CFG_LOWER, lo_set[s]);
            write_length(2'd2, 23'h555555);
            write_length(2'd3, 23'h2AAAAA);
            send_points(0, 0, 0, 0, 1, 1);
            send_points(-8388608, -8388608, 8388607, 8388607, 0, 0);
            for (int i = 0; i < 20; i++) send_random_points();
            drain_results();
        end
    endtask

    task automatic test_random_mix();
        write_length(CFG_UPPER, 23'd12800);
        write_length(CFG_LOWER, 23'd15360);
        for (int i = 0; i < 60; i++) begin
            idle_on = !(i >= 20 && i < 45);
            send_random_points();
        end
        idle_on = 1'b1;
        drain_results();
        write_length(CFG_UPPER, 23'($urandom()));
        write_length(CFG_LOWER, 23'($urandom_range(60000)));
        for (int i = 0; i < 30; i++) send_random_points();
        drain_results();
    endtask

    // The receiver holds off longer than the pipeline depth, so the sender
    // runs into a full pipeline and waits on s_tready.
    task automatic test_output_stall();
        idle_on = 1'b0;
        @(posedge aclk);
        hold_left <= STALL_LEN;
        for (int i = 0; i < 210; i++) send_random_points();
        idle_on = 1'b1;
        drain_results();
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        upper_len = UPPER_RESET;
        lower_len = LOWER_RESET;
        idle_on = 1'b1;
        hold_left = 0;
        errors = 0;
        solves_in = 0;
        solves_out = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_length_settings();
        test_random_mix();
        test_output_stall();
        $display("%0d solves sent, %0d checked over 9 length settings", solves_in, solves_out);
        $display("reach/far/close/same results: %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && knee_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
